// ===== src/button_short_long_press_classifier_macros.svh =====
// Assertion helpers for the button press classifier.
// Each check is sampled on the rising clock edge and disabled during reset.
`ifndef BUTTON_SHORT_LONG_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_SHORT_LONG_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication.
`define BSLP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bslp_pkg.sv =====
`default_nettype none

package bslp_pkg;

  localparam int LEVEL_W = 3;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 4;
  localparam int REG_IW  = 2;

  typedef logic [LEVEL_W-1:0] level_vec_t;
  typedef logic [TIME_W-1:0]  tick_t;
  typedef logic [CFG_W-1:0]   cfg_val_t;
  typedef logic [REG_IW-1:0]  reg_idx_t;

  // Register map, index = paddr / 4
  localparam reg_idx_t REG_DEBOUNCE  = 2'd0;
  localparam reg_idx_t REG_SHORT_MAX = 2'd1;
  localparam reg_idx_t REG_LONG_MIN  = 2'd2;

  localparam cfg_val_t DEBOUNCE_RST  = 16'd4;
  localparam cfg_val_t SHORT_MAX_RST = 16'd80;
  localparam cfg_val_t LONG_MIN_RST  = 16'd160;

  // Input command codes
  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_POLL = 1'b1;

endpackage

`default_nettype wire

// ===== src/bslp_if.sv =====
`default_nettype none

// Input channel: one poll or init item.
interface bslp_in_if;
  logic                valid;
  logic                ready;
  logic                cmd;
  bslp_pkg::level_vec_t raw_levels;
  bslp_pkg::tick_t     now_time;

  modport source (output valid, output cmd, output raw_levels, output now_time, input ready);
  modport sink   (input valid, input cmd, input raw_levels, input now_time, output ready);
endinterface

// Result channel: short and long event masks.
interface bslp_out_if;
  logic                valid;
  logic                ready;
  bslp_pkg::level_vec_t short_mask;
  bslp_pkg::level_vec_t long_mask;

  modport source (output valid, output short_mask, output long_mask, input ready);
  modport sink   (input valid, input short_mask, input long_mask, output ready);
endinterface

`default_nettype wire

// ===== src/button_short_long_press_classifier.sv =====
// Button short/long press classifier. Each input item is an init or a poll
// command with three active-high button levels and a free-running 32-bit
// tick time; each item gives exactly one result item with a short-press
// mask and a long-press mask (both zero for init). Debounce, short-press
// window and long-press threshold are programmed over the APB port at byte
// addresses 0x0, 0x4 and 0x8 (16 bits each, write only while idle).
// Throughput is one item per clock cycle; each item is held in the input
// register, then passes through the per-button compare logic into the
// result register. The result register and the input register stall
// together when the result is not taken, and an empty input register still
// takes a new item while a finished result waits.
`default_nettype none

`include "button_short_long_press_classifier_macros.svh"

module button_short_long_press_classifier #(
  parameter int BUTTONS = 3
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  bslp_in_if.sink                           in_ch,
  bslp_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bslp_pkg::APB_AW-1:0]  paddr,
  input  wire logic [bslp_pkg::APB_DW-1:0]  pwdata,
  output logic      [bslp_pkg::APB_DW-1:0]  prdata,
  output logic                              pready
);

  localparam int LW = bslp_pkg::LEVEL_W;
  localparam int TW = bslp_pkg::TIME_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  bslp_pkg::cfg_val_t debounce_r, short_max_r, long_min_r;
  bslp_pkg::reg_idx_t reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bslp_pkg::APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= bslp_pkg::DEBOUNCE_RST;
      short_max_r <= bslp_pkg::SHORT_MAX_RST;
      long_min_r  <= bslp_pkg::LONG_MIN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        bslp_pkg::REG_DEBOUNCE:  debounce_r  <= pwdata[bslp_pkg::CFG_W-1:0];
        bslp_pkg::REG_SHORT_MAX: short_max_r <= pwdata[bslp_pkg::CFG_W-1:0];
        bslp_pkg::REG_LONG_MIN:  long_min_r  <= pwdata[bslp_pkg::CFG_W-1:0];
        default: ;  // unmapped slot: drop the write
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bslp_pkg::REG_DEBOUNCE:  prdata = bslp_pkg::APB_DW'(debounce_r);
      bslp_pkg::REG_SHORT_MAX: prdata = bslp_pkg::APB_DW'(short_max_r);
      bslp_pkg::REG_LONG_MIN:  prdata = bslp_pkg::APB_DW'(long_min_r);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: both stages advance together whenever the result slot frees.
  // ---------------------------------------------------------------------------
  logic                 s1_valid_r;
  logic                 s1_cmd_r;
  bslp_pkg::level_vec_t s1_levels_r;
  bslp_pkg::tick_t      s1_now_r;
  logic                 out_valid_r;
  bslp_pkg::level_vec_t short_mask_r, long_mask_r;
  logic                 advance;
  logic                 in_take;
  logic                 fire;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign fire        = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // Payload holds when no item enters
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r    <= in_ch.cmd;
      s1_levels_r <= in_ch.raw_levels;
      s1_now_r    <= in_ch.now_time;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-button state
  // ---------------------------------------------------------------------------
  logic [BUTTONS-1:0] seen_r,   seen_nxt;
  logic [BUTTONS-1:0] stable_r, stable_nxt;
  logic [BUTTONS-1:0] ready_r,  ready_nxt;
  logic [BUTTONS-1:0] fired_r,  fired_nxt;
  bslp_pkg::tick_t    chg_time_r   [BUTTONS];
  bslp_pkg::tick_t    chg_time_nxt [BUTTONS];
  bslp_pkg::tick_t    press_time_r   [BUTTONS];
  bslp_pkg::tick_t    press_time_nxt [BUTTONS];
  logic [BUTTONS-1:0] short_vec, long_vec;

  // Buttons past the level field read released; mask bits past it drop.
  logic [BUTTONS+LW-1:0] lvl_wide;
  logic [BUTTONS-1:0]    lvl_vec;
  assign lvl_wide = {{BUTTONS{1'b0}}, s1_levels_r};
  assign lvl_vec  = lvl_wide[BUTTONS-1:0];

  logic is_poll;
  assign is_poll = (s1_cmd_r == bslp_pkg::CMD_POLL);

  always_comb begin
    bslp_pkg::tick_t deb_age;
    bslp_pkg::tick_t press_age;
    logic            raw_moved;
    logic            deb_ok;
    logic            new_press;
    for (int b = 0; b < BUTTONS; b++) begin
      seen_nxt[b]       = lvl_vec[b];
      stable_nxt[b]     = stable_r[b];
      ready_nxt[b]      = ready_r[b];
      fired_nxt[b]      = fired_r[b];
      chg_time_nxt[b]   = chg_time_r[b];
      press_time_nxt[b] = press_time_r[b];
      short_vec[b]      = 1'b0;
      long_vec[b]       = 1'b0;

      raw_moved = (lvl_vec[b] != seen_r[b]);
      deb_age   = raw_moved ? '0 : (s1_now_r - chg_time_r[b]);
      press_age = s1_now_r - press_time_r[b];
      deb_ok    = (lvl_vec[b] != stable_r[b]) && (deb_age >= TW'(debounce_r));
      new_press = deb_ok && lvl_vec[b];

      if (!is_poll) begin
        // Init: capture levels, hold off buttons already down
        stable_nxt[b]     = lvl_vec[b];
        ready_nxt[b]      = !lvl_vec[b];
        fired_nxt[b]      = 1'b0;
        chg_time_nxt[b]   = s1_now_r;
        press_time_nxt[b] = s1_now_r;
      end else begin
        if (raw_moved) begin
          chg_time_nxt[b] = s1_now_r;
        end
        if (deb_ok) begin
          stable_nxt[b] = lvl_vec[b];
          if (lvl_vec[b]) begin
            press_time_nxt[b] = s1_now_r;
            fired_nxt[b]      = 1'b0;
          end else if (!ready_r[b]) begin
            ready_nxt[b] = 1'b1;
          end else if (!fired_r[b] && (press_age <= TW'(short_max_r))) begin
            short_vec[b] = 1'b1;
          end
        end
        // A fresh press has zero age
        if (ready_nxt[b] && stable_nxt[b] && !fired_nxt[b] &&
            ((new_press ? '0 : press_age) >= TW'(long_min_r))) begin
          fired_nxt[b] = 1'b1;
          long_vec[b]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      stable_r <= '0;
      ready_r  <= '1;
      fired_r  <= '0;
      for (int b = 0; b < BUTTONS; b++) begin
        chg_time_r[b]   <= '0;
        press_time_r[b] <= '0;
      end
    end else if (fire) begin
      seen_r       <= seen_nxt;
      stable_r     <= stable_nxt;
      ready_r      <= ready_nxt;
      fired_r      <= fired_nxt;
      chg_time_r   <= chg_time_nxt;
      press_time_r <= press_time_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [BUTTONS+LW-1:0] short_wide, long_wide, fired_wide;
  assign short_wide = {{LW{1'b0}}, short_vec};
  assign long_wide  = {{LW{1'b0}}, long_vec};
  assign fired_wide = {{LW{1'b0}}, fired_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      short_mask_r <= short_wide[LW-1:0];
      long_mask_r  <= long_wide[LW-1:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.short_mask = short_mask_r;
  assign out_ch.long_mask  = long_mask_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Short needs a release, long needs the button down: never both at once.
  `BSLP_ASSERT_SAME(a_short_long_excl, out_valid_r, (short_mask_r & long_mask_r) == '0, "short and long event on one button")
  // Init items never report events.
  `BSLP_ASSERT_NEXT(a_init_quiet, fire && !is_poll, short_mask_r == '0 && long_mask_r == '0, "event on init item")
  // A reported long event leaves its button marked as fired.
  `BSLP_ASSERT_SAME(a_long_marks, out_valid_r, (long_mask_r & ~fired_wide[LW-1:0]) == '0, "long event without fired mark")
  // An empty input register always takes an item.
  `BSLP_ASSERT_SAME(a_in_open, !s1_valid_r, in_ch.ready, "input blocked while empty")

endmodule

`default_nettype wire

// ===== verif/button_short_long_press_classifier_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts the short/long
// press masks for every accepted item and compares them in order.
module button_press_checker
  import bslp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_cmd,
  input  level_vec_t        in_raw_levels,
  input  tick_t             in_now_time,
  input  logic              out_valid,
  input  logic              out_ready,
  input  level_vec_t        out_short_mask,
  input  level_vec_t        out_long_mask,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fail_count,
  output int                awaiting,
  output int                short_events,
  output int                long_events
);

  typedef struct packed {
    level_vec_t short_mask;
    level_vec_t long_mask;
  } press_events_t;

  press_events_t expected_events[$];

  cfg_val_t debounce_cfg;
  cfg_val_t short_max_cfg;
  cfg_val_t long_min_cfg;

  logic  seen_lvl   [LEVEL_W];
  logic  stable_lvl [LEVEL_W];
  logic  armed      [LEVEL_W];
  logic  long_done  [LEVEL_W];
  tick_t change_at  [LEVEL_W];
  tick_t pressed_at [LEVEL_W];

  int fails;
  int shorts_seen;
  int longs_seen;

  task automatic classify(input logic cmd, input level_vec_t lv, input tick_t now,
                          output press_events_t ev);
    tick_t since_change;
    tick_t held_for;
    logic  lvl;
    int    b;
    ev = '0;
    for (b = 0; b < LEVEL_W; b++) begin
      lvl = lv[b];
      if (cmd == CMD_INIT) begin
        // capture: a button already down must be released once before it counts
        seen_lvl[b]   = lvl;
        stable_lvl[b] = lvl;
        armed[b]      = !lvl;
        long_done[b]  = 1'b0;
        change_at[b]  = now;
        pressed_at[b] = now;
      end else begin
        if (lvl != seen_lvl[b]) begin
          seen_lvl[b]  = lvl;
          change_at[b] = now;
        end
        since_change = now - change_at[b];
        if (seen_lvl[b] != stable_lvl[b] && since_change >= tick_t'(debounce_cfg)) begin
          stable_lvl[b] = seen_lvl[b];
          held_for = now - pressed_at[b];
          if (stable_lvl[b]) begin
            pressed_at[b] = now;
            long_done[b]  = 1'b0;
          end else if (!armed[b]) begin
            armed[b] = 1'b1;
          end else if (!long_done[b] && held_for <= tick_t'(short_max_cfg)) begin
            ev.short_mask[b] = 1'b1;
          end
        end
        held_for = now - pressed_at[b];
        if (armed[b] && stable_lvl[b] && !long_done[b] &&
            held_for >= tick_t'(long_min_cfg)) begin
          long_done[b]    = 1'b1;
          ev.long_mask[b] = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    press_events_t ev;
    int b;
    if (!rst_n) begin
      debounce_cfg  = DEBOUNCE_RST;
      short_max_cfg = SHORT_MAX_RST;
      long_min_cfg  = LONG_MIN_RST;
      for (b = 0; b < LEVEL_W; b++) begin
        seen_lvl[b]   = 1'b0;
        stable_lvl[b] = 1'b0;
        armed[b]      = 1'b1;
        long_done[b]  = 1'b0;
        change_at[b]  = '0;
        pressed_at[b] = '0;
      end
      expected_events.delete();
      fails       = 0;
      shorts_seen = 0;
      longs_seen  = 0;
    end else begin
      // results leaving now belong to items taken at earlier edges
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: result with nothing pending: short %b long %b",
                   $time, out_short_mask, out_long_mask);
          fails++;
        end else begin
          ev = expected_events.pop_front();
          if (out_short_mask !== ev.short_mask) begin
            $display("%0t: short_mask expected %b actual %b", $time, ev.short_mask,
                     out_short_mask);
            fails++;
          end
          if (out_long_mask !== ev.long_mask) begin
            $display("%0t: long_mask expected %b actual %b", $time, ev.long_mask,
                     out_long_mask);
            fails++;
          end
          shorts_seen += $countones(ev.short_mask);
          longs_seen  += $countones(ev.long_mask);
        end
      end
      if (in_valid && in_ready) begin
        classify(in_cmd, in_raw_levels, in_now_time, ev);
        expected_events.push_back(ev);
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_DEBOUNCE:  debounce_cfg  = pwdata[CFG_W-1:0];
          REG_SHORT_MAX: short_max_cfg = pwdata[CFG_W-1:0];
          REG_LONG_MIN:  long_min_cfg  = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count   <= fails;
    awaiting     <= expected_events.size();
    short_events <= shorts_seen;
    long_events  <= longs_seen;
  end

endmodule

// ===== verif/button_short_long_press_classifier_tb.sv =====
`timescale 1ns / 100ps

// Top of the press classifier bench: makes stimulus, handles the result
// channel backpressure and gives the verdict. All checking is in the checker.
module button_short_long_press_classifier_tb;
  import bslp_pkg::*;

  // index 3 has no register behind it; writes there must be ignored
  localparam reg_idx_t REG_UNMAPPED = 2'd3;
  localparam int       PHASES       = 9;
  localparam int       PHASE_ITEMS  = 190;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int fail_count;
  int awaiting;
  int short_events;
  int long_events;

  int n_init;
  int n_poll;
  int n_settings;

  // when set, the side runs without gaps; flipped now and then per item
  bit in_steady;
  bit out_steady;

  bslp_in_if  in_bus ();
  bslp_out_if out_bus ();

  button_short_long_press_classifier uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  button_press_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_bus.valid),
    .in_ready       (in_bus.ready),
    .in_cmd         (in_bus.cmd),
    .in_raw_levels  (in_bus.raw_levels),
    .in_now_time    (in_bus.now_time),
    .out_valid      (out_bus.valid),
    .out_ready      (out_bus.ready),
    .out_short_mask (out_bus.short_mask),
    .out_long_mask  (out_bus.long_mask),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .awaiting       (awaiting),
    .short_events   (short_events),
    .long_events    (long_events)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: draw a stall per item, then hold ready until one is taken.
  // With a zero stall ready simply stays high into the next item.
  initial begin : result_sink
    int stall;
    out_bus.ready <= 1'b0;
    out_steady = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  // Present one item after a random gap and hold it until it is taken.
  task automatic send_item(input logic cmd, input level_vec_t lv, input tick_t now);
    int gap;
    if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.cmd        <= cmd;
    in_bus.raw_levels <= lv;
    in_bus.now_time   <= now;
    do @(posedge clk); while (!in_bus.ready);
    if (cmd == CMD_INIT) n_init++;
    else n_poll++;
  endtask

  // Setup cycle, access cycle, then idle with psel low so back-to-back writes
  // never touch psel twice in one step.
  task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every pending result, then let the pipe drain.
  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  // Upper data bits carry junk; only the low 16 bits may stick.
  task automatic program_regs(input cfg_val_t dbnc, input cfg_val_t short_max,
                              input cfg_val_t long_min);
    reg_write(REG_DEBOUNCE,  {16'($urandom()), dbnc});
    reg_write(REG_SHORT_MAX, {16'($urandom()), short_max});
    reg_write(REG_LONG_MIN,  {16'($urandom()), long_min});
    if ($urandom_range(0, 1) == 0) reg_write(REG_UNMAPPED, $urandom());
    n_settings++;
  endtask

  // Known sequence under reset settings (debounce 4, short 80, long 160):
  // buttons held at init, bounces, a short press, a long press with its
  // release, short press exactly at the window edge across a time wrap and
  // one tick past it.
  task automatic run_directed();
    send_item(CMD_INIT, 3'b101, 32'd100);
    send_item(CMD_POLL, 3'b000, 32'd101);
    send_item(CMD_POLL, 3'b000, 32'd105);
    send_item(CMD_POLL, 3'b011, 32'd106);
    send_item(CMD_POLL, 3'b001, 32'd108);
    send_item(CMD_POLL, 3'b001, 32'd110);
    send_item(CMD_POLL, 3'b000, 32'd150);
    send_item(CMD_POLL, 3'b000, 32'd154);
    send_item(CMD_POLL, 3'b100, 32'd200);
    send_item(CMD_POLL, 3'b100, 32'd204);
    send_item(CMD_POLL, 3'b100, 32'd364);
    send_item(CMD_POLL, 3'b100, 32'd400);
    send_item(CMD_POLL, 3'b000, 32'd401);
    send_item(CMD_POLL, 3'b000, 32'd405);
    send_item(CMD_POLL, 3'b010, 32'hFFFF_FFF0);
    send_item(CMD_POLL, 3'b010, 32'hFFFF_FFF4);
    send_item(CMD_POLL, 3'b000, 32'h0000_0040);
    send_item(CMD_POLL, 3'b000, 32'h0000_0044);
    send_item(CMD_POLL, 3'b010, 32'h0000_0045);
    send_item(CMD_POLL, 3'b010, 32'h0000_0049);
    send_item(CMD_POLL, 3'b000, 32'h0000_0096);
    send_item(CMD_POLL, 3'b000, 32'h0000_009A);
    send_item(CMD_INIT, 3'b111, 32'hFFFF_FFFF);
    send_item(CMD_POLL, 3'b111, 32'hFFFF_FFFF);
    send_item(CMD_INIT, 3'b000, 32'h0000_0000);
  endtask

  // Mostly realistic polling: time moves forward, each button holds a level
  // for a random run of polls, with single-poll bounces. Sprinkle in re-inits
  // and wild time jumps as noise.
  task automatic random_session(input int count, input int unsigned scale);
    level_vec_t  held;
    level_vec_t  lv;
    tick_t       t;
    int          hold_left [LEVEL_W];
    int          k;
    int          b;
    if ($urandom_range(0, 3) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 4 * scale + 100);
    else t = $urandom();
    held = level_vec_t'($urandom_range(0, 7));
    for (b = 0; b < LEVEL_W; b++) hold_left[b] = $urandom_range(1, 40);
    send_item(CMD_INIT, held, t);
    for (k = 1; k < count; k++) begin
      case ($urandom_range(0, 59))
        0: begin
          held = level_vec_t'($urandom_range(0, 7));
          send_item(CMD_INIT, held, t);
        end
        1: begin
          t = $urandom();
          send_item(CMD_POLL, level_vec_t'($urandom_range(0, 7)), t);
        end
        default: begin
          t += $urandom_range(0, scale);
          for (b = 0; b < LEVEL_W; b++) begin
            hold_left[b]--;
            if (hold_left[b] <= 0) begin
              held[b] = !held[b];
              hold_left[b] = $urandom_range(0, 1) ? $urandom_range(1, 6)
                                                  : $urandom_range(7, 40);
            end
          end
          lv = held;
          if ($urandom_range(0, 9) == 0) lv[$urandom_range(0, LEVEL_W - 1)] ^= 1'b1;
          send_item(CMD_POLL, lv, t);
        end
      endcase
    end
  endtask

  initial begin : stimulus
    cfg_val_t    dbnc;
    cfg_val_t    short_max;
    cfg_val_t    long_min;
    int unsigned scale;
    int          p;
    in_bus.valid      <= 1'b0;
    in_bus.cmd        <= CMD_INIT;
    in_bus.raw_levels <= '0;
    in_bus.now_time   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    n_init     = 0;
    n_poll     = 0;
    n_settings = 1;
    in_steady  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    settle();

    for (p = 0; p < PHASES; p++) begin
      // extremes first, then reset values rewritten, then random settings
      case (p)
        0: begin dbnc = 16'd0;     short_max = 16'd0;     long_min = 16'd0;     end
        1: begin dbnc = 16'hFFFF;  short_max = 16'hFFFF;  long_min = 16'hFFFF;  end
        2: begin dbnc = 16'd0;     short_max = 16'hFFFF;  long_min = 16'hFFFF;  end
        3: begin dbnc = 16'hFFFF;  short_max = 16'd0;     long_min = 16'd1;     end
        4: begin dbnc = DEBOUNCE_RST; short_max = SHORT_MAX_RST; long_min = LONG_MIN_RST; end
        default: begin
          dbnc      = cfg_val_t'($urandom_range(0, 12));
          short_max = cfg_val_t'($urandom_range(0, 120));
          long_min  = cfg_val_t'($urandom_range(0, 250));
        end
      endcase
      program_regs(dbnc, short_max, long_min);
      // size time steps to the largest threshold so every window is reachable
      scale = dbnc;
      if (short_max > scale) scale = short_max;
      if (long_min > scale) scale = long_min;
      scale = scale / 4 + 1;
      random_session(PHASE_ITEMS, scale);
      settle();
    end

    $display("Run covered %0d init and %0d poll items over %0d register settings.",
             n_init, n_poll, n_settings);
    $display("Predicted and matched %0d short and %0d long press events.",
             short_events, long_events);
    if (fail_count == 0 && awaiting == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/bslp_pkg.sv
src/bslp_if.sv
src/button_short_long_press_classifier.sv
verif/button_short_long_press_classifier_checker.sv
verif/button_short_long_press_classifier_tb.sv
